>>> rtl/double_ended_queue_unit_defines.svh
// Assertion macros shared by the deque RTL.
// Included by double_ended_queue_unit.sv; no other dependencies.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define DEQ_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("deque assertion failed");
`define DEQ_NEVER(lbl, clk, rst, expr) \
   `DEQ_ASSERT(lbl, clk, rst, !(expr))
`else
`define DEQ_ASSERT(lbl, clk, rst, prop)
`define DEQ_NEVER(lbl, clk, rst, expr)
`endif
`endif

>>> rtl/deq_pkg.sv
// Types and constants for the double-ended queue unit.
// No dependencies; imported by deq_cell, deq_chain and the top level.
`default_nettype none
package deq_pkg;

   localparam int DATA_W  = 32;
   localparam int COUNT_W = 11;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5,
      OP_SIZE       = 3'd6,
      OP_CLEAR      = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // What one cell does this cycle.
   typedef enum logic [1:0] {
      CELL_HOLD = 2'd0,
      CELL_UP   = 2'd1,   // take the neighbor below (entry moves away from the head)
      CELL_DOWN = 2'd2,   // take the neighbor above (entry moves toward the head)
      CELL_LOAD = 2'd3    // take the write value
   } cell_op_type;

   // Command from the top level to one chain.
   typedef struct packed {
      logic shift_up;     // insert at the head cell
      logic shift_down;   // drop the head cell
      logic load;         // write at the indexed cell
   } chain_ctrl_type;

endpackage
`default_nettype wire

>>> rtl/deq_cell.sv
// One storage cell of the deque chain.
// Depends on deq_pkg.
`default_nettype none
module deq_cell (
   input  wire logic                         clock,
   input  wire deq_pkg::cell_op_type         cell_op,
   input  wire logic signed [deq_pkg::DATA_W-1:0] from_lower,
   input  wire logic signed [deq_pkg::DATA_W-1:0] from_upper,
   input  wire logic signed [deq_pkg::DATA_W-1:0] load_value,
   output logic signed [deq_pkg::DATA_W-1:0]      q
);
   import deq_pkg::*;

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;

   always_comb begin
      case (cell_op)
         CELL_UP:   data_in = from_lower;
         CELL_DOWN: data_in = from_upper;
         CELL_LOAD: data_in = load_value;
         default:   data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign q = data_ff;

endmodule
`default_nettype wire

>>> rtl/deq_chain.sv
// Row of DEPTH cells holding one ordering of the deque, head at cell 0.
// Depends on deq_pkg and deq_cell.
`default_nettype none
module deq_chain #(
   parameter int DEPTH = 1024
) (
   input  wire logic                               clock,
   input  wire deq_pkg::chain_ctrl_type            ctrl,
   input  wire logic [$clog2(DEPTH)-1:0]           wr_index,
   input  wire logic signed [deq_pkg::DATA_W-1:0]  wr_value,
   output logic signed [deq_pkg::DATA_W-1:0]       head_value
);
   import deq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);

   logic signed [DATA_W-1:0] cell_q [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] lower;
      logic signed [DATA_W-1:0] upper;
      cell_op_type              op;

      if (i == 0) begin : g_first
         assign lower = wr_value;
      end else begin : g_mid_lo
         assign lower = cell_q[i-1];
      end

      if (i == DEPTH-1) begin : g_last
         assign upper = cell_q[i];
      end else begin : g_mid_hi
         assign upper = cell_q[i+1];
      end

      always_comb begin
         if (ctrl.shift_up) begin
            op = CELL_UP;
         end else if (ctrl.shift_down) begin
            op = CELL_DOWN;
         end else if (ctrl.load && (wr_index == IDX_W'(i))) begin
            op = CELL_LOAD;
         end else begin
            op = CELL_HOLD;
         end
      end

      deq_cell u_cell (
         .clock      (clock),
         .cell_op    (op),
         .from_lower (lower),
         .from_upper (upper),
         .load_value (wr_value),
         .q          (cell_q[i])
      );
   end

   assign head_value = cell_q[0];

endmodule
`default_nettype wire

>>> rtl/double_ended_queue_unit.sv
// Top level of the double-ended queue of signed 32-bit words.
// Depends on deq_pkg, deq_chain, deq_cell and double_ended_queue_unit_defines.svh.
//
// Usage:
//   Command channel: drive req_operation and req_value with start high; a beat
//   is taken at each rising edge with start high and busy low. busy stays low,
//   so a command can be issued in every cycle.
//   Result channel: one beat per command, on rsp_status, rsp_data and
//   rsp_count, marked by rsp_valid for exactly one cycle, in the cycle
//   after the command beat. The receiver cannot stall it; take it when it shows.
//   Throughput: one command per cycle, set by the cell chains: every entry
//   sits in a register cell, the front and back words are always at cell 0
//   of their chain, and a push or pop is one shift or one indexed write
//   across the chain.
//   Storage: two chains of DEPTH cells. The front chain holds the entries in
//   order from the front, the back chain in order from the back; each push
//   shifts one chain and writes the free end of the other.
//   Reset: synchronous, active high; empties the queue and drops any result
//   in flight. No clearing pass: cell contents stay unused until pushed.
`default_nettype none
`include "double_ended_queue_unit_defines.svh"
module double_ended_queue_unit #(
   parameter int DEPTH = 1024
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [2:0]                         req_operation,
   input  wire logic signed [deq_pkg::DATA_W-1:0]  req_value,
   output logic                                    rsp_valid,
   output logic [1:0]                              rsp_status,
   output logic signed [deq_pkg::DATA_W-1:0]       rsp_data,
   output logic [deq_pkg::COUNT_W-1:0]             rsp_count
);
   import deq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   // Entry count and result registers
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic                     rsp_valid_ff;
   status_type               rsp_status_ff;
   status_type               rsp_status_in;
   logic signed [DATA_W-1:0] rsp_data_ff;
   logic signed [DATA_W-1:0] rsp_data_in;
   logic [COUNT_W-1:0]       rsp_count_ff;

   logic                     accept;
   logic                     empty;
   logic                     full;
   op_type                   op;
   chain_ctrl_type           front_ctrl;
   chain_ctrl_type           back_ctrl;
   logic signed [DATA_W-1:0] front_head;
   logic signed [DATA_W-1:0] back_head;
   logic [IDX_W-1:0]         wr_index;
   logic                     push_cmd;
   logic                     rsp_full;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign op     = op_type'(req_operation);
   assign empty  = (count_ff == '0);
   assign full   = (count_ff == DEPTH_CNT);
   // The free end of a chain sits at the current count; only used when not full.
   assign wr_index = count_ff[IDX_W-1:0];

   // Decode the command: pick the chain moves, the status and the read word.
   always_comb begin
      count_in      = count_ff;
      rsp_status_in = ST_OK;
      rsp_data_in   = '0;
      front_ctrl    = '0;
      back_ctrl     = '0;
      if (accept) begin
         case (op)
            OP_PUSH_FRONT: begin
               if (full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  front_ctrl.shift_up = 1'b1;
                  back_ctrl.load      = 1'b1;
                  count_in            = count_ff + 1'b1;
               end
            end
            OP_PUSH_BACK: begin
               if (full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  back_ctrl.shift_up = 1'b1;
                  front_ctrl.load    = 1'b1;
                  count_in           = count_ff + 1'b1;
               end
            end
            OP_POP_FRONT: begin
               if (empty) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rsp_data_in           = front_head;
                  front_ctrl.shift_down = 1'b1;
                  count_in              = count_ff - 1'b1;
               end
            end
            OP_POP_BACK: begin
               if (empty) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rsp_data_in          = back_head;
                  back_ctrl.shift_down = 1'b1;
                  count_in             = count_ff - 1'b1;
               end
            end
            OP_PEEK_FRONT: begin
               if (empty) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rsp_data_in = front_head;
               end
            end
            OP_PEEK_BACK: begin
               if (empty) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rsp_data_in = back_head;
               end
            end
            OP_SIZE: begin
               count_in = count_ff;
            end
            OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   // Control state: count and result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   // Result payload: load on every accepted beat, hold otherwise.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_count_ff  <= COUNT_W'(count_in);
      end
   end

   // Front-ordered entries: cell 0 is the front word.
   deq_chain #(.DEPTH(DEPTH)) u_front (
      .clock      (clock),
      .ctrl       (front_ctrl),
      .wr_index   (wr_index),
      .wr_value   (req_value),
      .head_value (front_head)
   );

   // Back-ordered entries: cell 0 is the back word.
   deq_chain #(.DEPTH(DEPTH)) u_back (
      .clock      (clock),
      .ctrl       (back_ctrl),
      .wr_index   (wr_index),
      .wr_value   (req_value),
      .head_value (back_head)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_count  = rsp_count_ff;

   // Terms for the checks below.
   assign push_cmd = accept && !full && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK);
   assign rsp_full = rsp_valid_ff && (rsp_status_ff == ST_FULL);

   `DEQ_NEVER(a_count_bound, clock, reset, count_ff > DEPTH_CNT)
   `DEQ_ASSERT(a_rsp_follows_cmd, clock, reset, accept |=> rsp_valid_ff)
   `DEQ_ASSERT(a_rsp_has_cmd, clock, reset, rsp_valid_ff |-> $past(accept))
   `DEQ_ASSERT(a_push_grows, clock, reset, push_cmd |=> (count_ff == $past(count_ff) + 1'b1))
   `DEQ_ASSERT(a_full_only_at_depth, clock, reset, rsp_full |-> full)

endmodule
`default_nettype wire

>>> verif/tb_double_ended_queue_unit.sv
// Self-checking testbench for double_ended_queue_unit: directed table, fill, random mix.
// Depends on deq_pkg and the double_ended_queue_unit RTL; needs nothing else.
module tb_double_ended_queue_unit;
   import deq_pkg::*;

   localparam int QUEUE_DEPTH = 1024;
   localparam int STALL_LIMIT = 1000;   // cycles with no beat on either side
   localparam int SEG_ITEMS   = 60;
   localparam int SEGS_PER_PH = 1;      // 3 phases x 1 x 60 random commands, plus the fill

   // One result beat as the block reports it.
   typedef struct packed {
      status_type         status;
      logic [DATA_W-1:0]  data;
      logic [COUNT_W-1:0] count;
   } deq_result_type;

   // One row of the directed table; typed rows carry their result inline.
   typedef struct packed {
      op_type             op;
      logic [DATA_W-1:0]  value;
      bit                 typed;
      status_type         status;
      logic [DATA_W-1:0]  data;
      logic [COUNT_W-1:0] count;
   } deq_row_type;

   localparam int N_ROWS = 25;
   localparam deq_row_type DIRECTED_ROWS [0:N_ROWS-1] = '{
      // every read on an empty queue after reset
      '{OP_SIZE,       32'h0000_0000, 1'b1, ST_OK,    32'h0000_0000, 11'd0},
      '{OP_POP_FRONT,  32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000, 11'd0},
      '{OP_POP_BACK,   32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000, 11'd0},
      '{OP_PEEK_FRONT, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000, 11'd0},
      '{OP_PEEK_BACK,  32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000, 11'd0},
      // extreme words at both ends; the front push wraps the head below zero
      '{OP_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, ST_OK,    32'h0000_0000, 11'd1},
      '{OP_PUSH_FRONT, 32'h8000_0000, 1'b1, ST_OK,    32'h0000_0000, 11'd2},
      '{OP_PEEK_FRONT, 32'h0000_0000, 1'b1, ST_OK,    32'h8000_0000, 11'd2},
      '{OP_PEEK_BACK,  32'h0000_0000, 1'b1, ST_OK,    32'h7FFF_FFFF, 11'd2},
      '{OP_PUSH_BACK,  32'h0000_0000, 1'b1, ST_OK,    32'h0000_0000, 11'd3},
      '{OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, ST_OK,    32'h0000_0000, 11'd4},
      '{OP_PUSH_BACK,  32'h0000_0001, 1'b1, ST_OK,    32'h0000_0000, 11'd5},
      // value is ignored by pops and size
      '{OP_POP_BACK,   32'hFFFF_FFFF, 1'b1, ST_OK,    32'h0000_0001, 11'd4},
      '{OP_POP_FRONT,  32'h0000_0000, 1'b1, ST_OK,    32'hFFFF_FFFF, 11'd3},
      '{OP_SIZE,       32'hFFFF_FFFF, 1'b1, ST_OK,    32'h0000_0000, 11'd3},
      '{OP_POP_FRONT,  32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000, 11'd0},
      '{OP_POP_BACK,   32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000, 11'd0},
      // clear with an entry still held, then read the empty queue
      '{OP_CLEAR,      32'h5555_5555, 1'b1, ST_OK,    32'h0000_0000, 11'd0},
      '{OP_PEEK_BACK,  32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000, 11'd0},
      '{OP_PUSH_FRONT, 32'hAAAA_AAAA, 1'b1, ST_OK,    32'h0000_0000, 11'd1},
      '{OP_PUSH_BACK,  32'h5555_5555, 1'b1, ST_OK,    32'h0000_0000, 11'd2},
      '{OP_PEEK_FRONT, 32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000, 11'd0},
      '{OP_POP_BACK,   32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000, 11'd0},
      '{OP_POP_FRONT,  32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000, 11'd0},
      // clear of an already empty queue
      '{OP_CLEAR,      32'h0000_0000, 1'b1, ST_OK,    32'h0000_0000, 11'd0}
   };

   // DUT pins; the driven inputs are known from time zero.
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [2:0]          req_operation = OP_SIZE;
   logic [DATA_W-1:0]   req_value = '0;
   logic                rsp_valid;
   logic [1:0]          rsp_status;
   logic [DATA_W-1:0]   rsp_data;
   logic [COUNT_W-1:0]  rsp_count;

   // Mirror of the deque contents as a ring: words, front index, occupancy.
   logic [DATA_W-1:0]   ring_words [QUEUE_DEPTH];
   int unsigned         ring_head = 0;
   int unsigned         ring_count = 0;

   // Results owed by the block, oldest first.
   deq_result_type      rsp_backlog [$];

   int                  fail_count = 0;
   int                  stall_cycles = 0;
   int                  cmd_total = 0;
   int                  full_rejects = 0;
   int                  empty_rejects = 0;
   int unsigned         peak_count = 0;

   double_ended_queue_unit #(.DEPTH(QUEUE_DEPTH)) u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_data      (rsp_data),
      .rsp_count     (rsp_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Apply one command to the mirrored ring and return the result it yields.
   function automatic deq_result_type apply_deque_op(input op_type op,
                                                     input logic [DATA_W-1:0] val);
      deq_result_type r;
      int unsigned slot;
      r.status = ST_OK;
      r.data   = '0;
      slot     = 0;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (ring_count >= QUEUE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               if (op == OP_PUSH_FRONT) begin
                  // step the head back one slot, wrapping below zero
                  ring_head = (ring_head == 0) ? QUEUE_DEPTH - 1 : ring_head - 1;
                  slot = ring_head;
               end else begin
                  slot = (ring_head + ring_count) % QUEUE_DEPTH;
               end
               ring_words[slot] = val;
               ring_count++;
            end
         end
         OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
            if (ring_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               if (op == OP_POP_FRONT || op == OP_PEEK_FRONT)
                  slot = ring_head;
               else
                  slot = (ring_head + ring_count - 1) % QUEUE_DEPTH;
               r.data = ring_words[slot];
               if (op == OP_POP_FRONT) begin
                  ring_head = (ring_head + 1) % QUEUE_DEPTH;
                  ring_count--;
               end else if (op == OP_POP_BACK) begin
                  ring_count--;
               end
            end
         end
         OP_SIZE: begin
         end
         default: begin
            // clear: drop every entry, stored words become stale
            ring_head  = 0;
            ring_count = 0;
         end
      endcase
      r.count = ring_count[COUNT_W-1:0];
      return r;
   endfunction

   // Draw a command: clear_pct percent clears, push_pct percent pushes,
   // the rest spread over pops, peeks and size.
   function automatic op_type pick_op(input int push_pct, input int clear_pct);
      int roll;
      roll = $urandom_range(99);
      if (roll < clear_pct)
         return OP_CLEAR;
      if (roll < clear_pct + push_pct)
         return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      return op_type'($urandom_range(6, 2));
   endfunction

   // Present one command and hold it until the block takes the beat. Record
   // the owed result at the accepting edge; typed rows supply their own.
   task automatic issue_cmd(input op_type op, input logic [DATA_W-1:0] val,
                            input bit typed, input deq_result_type typed_rsp);
      deq_result_type predicted;
      start         <= 1'b1;
      req_operation <= op;
      req_value     <= val;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = apply_deque_op(op, val);
      rsp_backlog = {rsp_backlog, (typed ? typed_rsp : predicted)};
      cmd_total++;
      if (predicted.status == ST_FULL)  full_rejects++;
      if (predicted.status == ST_EMPTY) empty_rejects++;
      if (ring_count > peak_count) peak_count = ring_count;
   endtask

   // Hold start low for a random run of cycles; idle_pct is the odds per cycle.
   task automatic sender_gap(input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Issue n random commands with the given mix and sender idling.
   task automatic run_items(input int n, input int push_pct, input int clear_pct,
                            input int idle_pct);
      for (int i = 0; i < n; i++) begin
         sender_gap(idle_pct);
         issue_cmd(pick_op(push_pct, clear_pct), $urandom, 1'b0, '0);
      end
   endtask

   // Stop sending and wait until every owed result has come back.
   task automatic drain_backlog();
      start <= 1'b0;
      do @(posedge clock); while (rsp_backlog.size() != 0);
   endtask

   // Result checker: sample at the edge that accepts the beat, compare each
   // field against the oldest owed result.
   always @(posedge clock) begin : rsp_check
      deq_result_type want;
      if (!reset && rsp_valid) begin
         if (rsp_backlog.size() == 0) begin
            $error("unexpected result beat: status %0d data %h count %0d",
                   rsp_status, rsp_data, rsp_count);
            fail_count++;
         end else begin
            want = rsp_backlog[0];
            rsp_backlog.delete(0);
            if (rsp_status !== want.status) begin
               $error("rsp_status mismatch: expected %0d, got %0d",
                      want.status, rsp_status);
               fail_count++;
            end
            if (rsp_data !== want.data) begin
               $error("rsp_data mismatch: expected %h, got %h", want.data, rsp_data);
               fail_count++;
            end
            if (rsp_count !== want.count) begin
               $error("rsp_count mismatch: expected %0d, got %0d",
                      want.count, rsp_count);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: any beat on either side restarts the count.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int idle_pct;
      deq_result_type row_rsp;

      // Hold reset, then release it once for the whole run.
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table back to back; typed rows carry their answer.
      for (int r = 0; r < N_ROWS; r++) begin
         row_rsp.status = DIRECTED_ROWS[r].status;
         row_rsp.data   = DIRECTED_ROWS[r].data;
         row_rsp.count  = DIRECTED_ROWS[r].count;
         issue_cmd(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].value,
                   DIRECTED_ROWS[r].typed, row_rsp);
      end
      drain_backlog();

      // Random part in three idling phases: 32 percent, 66 percent, none.
      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = (ph == 0) ? 32 : (ph == 1) ? 66 : 0;
         for (int s = 0; s < SEGS_PER_PH; s++) begin
            // vary the push bias per segment so occupancy rises and falls
            run_items(SEG_ITEMS, 25 * $urandom_range(3, 1), 2, idle_pct);
         end
         if (ph == 0) begin
            // Fill to capacity with random words at random ends, then hammer
            // the full queue so pushes get rejected and pops free slots again.
            while (ring_count < QUEUE_DEPTH) begin
               sender_gap(idle_pct);
               issue_cmd(pick_op(97, 0), $urandom, 1'b0, '0);
            end
            run_items(40, 60, 0, idle_pct);
            issue_cmd(OP_CLEAR, $urandom, 1'b0, '0);
         end
         // Pause until every owed result is back before the next phase.
         drain_backlog();
      end

      // Let any stray beat show up before the verdict.
      repeat (5) @(posedge clock);
      $display("Summary: %0d commands, peak occupancy %0d of %0d entries,",
               cmd_total, peak_count, QUEUE_DEPTH);
      $display("         %0d full-queue rejects, %0d empty-queue rejects, %0d mismatches",
               full_rejects, empty_rejects, fail_count);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> double_ended_queue_unit.f
+incdir+rtl
rtl/deq_pkg.sv
rtl/deq_cell.sv
rtl/deq_chain.sv
rtl/double_ended_queue_unit.sv
verif/tb_double_ended_queue_unit.sv
